@@ design/ppp_pkg.sv @@
`default_nettype none

package ppp_pkg;

    // Default width of the in-message byte index; a message holds at most
    // 2**POSITION_BITS bytes.
    localparam int unsigned POSITION_BITS_DEFAULT = 16;

    localparam int unsigned DATA_BYTE_W   = 8;
    localparam int unsigned PORT_W        = 32;
    localparam int unsigned PAYLOAD_W     = 16;
    localparam int unsigned VARINT_W      = 64;
    localparam int unsigned VARINT_MAX_B  = 10;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_DELIM  = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam logic [4:0] FIXED64_BYTES = 5'd8;
    localparam logic [4:0] FIXED32_BYTES = 5'd4;

    // Result beat width: 1 + 32 + 1 + 16 + 16 = 66 bits, padded to 72.
    localparam int unsigned RESULT_W  = 66;
    localparam int unsigned M_TDATA_W = 72;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_VAL  = 2'd1,
        PH_LEN  = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload_length;
        logic [PAYLOAD_W-1:0] payload_offset;
        logic                 payload_present;
        logic [PORT_W-1:0]    port_number;
        logic                 parse_ok;
    } result_t;

    // One accepted input byte handed from the input register to the decoder.
    typedef struct packed {
        logic                   valid;
        logic                   final_byte;
        logic [DATA_BYTE_W-1:0] data_byte;
    } byte_beat_t;

endpackage

`default_nettype wire

@@ design/ppp_byte_stage.sv @@
`default_nettype none

module ppp_byte_stage
    import ppp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [DATA_BYTE_W-1:0] in_byte,
    input  wire logic                   in_final,
    input  wire logic                   out_free,
    output byte_beat_t                  beat
);

    logic                   valid_reg;
    logic                   valid_next;
    logic                   final_reg;
    logic [DATA_BYTE_W-1:0] byte_reg;
    logic                   advance;

    // A held byte moves on unless it ends a message and the result slot is full.
    assign advance  = valid_reg && (!final_reg || out_free);
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= in_byte;
            final_reg <= in_final;
        end
    end

    assign beat.valid      = advance;
    assign beat.final_byte = final_reg;
    assign beat.data_byte  = byte_reg;

endmodule

`default_nettype wire

@@ design/ppp_decoder.sv @@
`default_nettype none

module ppp_decoder
    import ppp_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire byte_beat_t beat,
    output logic            res_valid,
    output result_t         res
);

    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned SW = POSITION_BITS + 1;
    localparam logic [PB-1:0] POS_LAST = {PB{1'b1}};
    localparam logic [VARINT_W-1:0] SKIP_CAP = VARINT_W'(64'd1 << PB);

    phase_t                phase_reg, phase_next;
    logic [VARINT_W-1:0]   accum_reg, accum_next;
    logic [3:0]            count_reg, count_next;
    logic                  field_port_reg, field_port_next;
    logic                  field_payload_reg, field_payload_next;
    logic [SW-1:0]         skip_reg, skip_next;
    logic [PB-1:0]         pos_reg, pos_next;
    logic [PORT_W-1:0]     port_reg, port_next;
    logic [SW-1:0]         start_reg, start_next;
    logic [PAYLOAD_W-1:0]  size_reg, size_next;
    logic                  seen_reg, seen_next;
    logic                  error_reg, error_next;

    logic [VARINT_W-1:0]   varint_val;
    logic [6:0]            shift_amt;
    logic [SW-1:0]         skip_dec;
    logic [SW-1:0]         len_clamped;
    logic                  ok;

    // Shift for the next 7-bit group is 7 * count.
    assign shift_amt  = {count_reg, 3'b000} - {3'b000, count_reg};
    assign varint_val = accum_reg
                      | (VARINT_W'(beat.data_byte[6:0]) << shift_amt);
    assign skip_dec   = skip_reg - SW'(1);
    assign len_clamped = (varint_val > SKIP_CAP) ? SW'(SKIP_CAP) : SW'(varint_val);

    always_comb
    begin
        phase_next         = phase_reg;
        accum_next         = accum_reg;
        count_next         = count_reg;
        field_port_next    = field_port_reg;
        field_payload_next = field_payload_reg;
        skip_next          = skip_reg;
        pos_next           = pos_reg;
        port_next          = port_reg;
        start_next         = start_reg;
        size_next          = size_reg;
        seen_next          = seen_reg;
        error_next         = error_reg;
        res_valid          = 1'b0;
        res                = '0;
        ok                 = 1'b0;

        if (beat.valid)
        begin
            if (!error_reg)
            begin
                if (phase_reg == PH_SKIP)
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
                else if (count_reg >= 4'(VARINT_MAX_B))
                begin
                    error_next = 1'b1;
                end
                else if (beat.data_byte[7])
                begin
                    accum_next = varint_val;
                    count_next = count_reg + 4'd1;
                end
                else
                begin
                    accum_next = '0;
                    count_next = '0;
                    case (phase_reg)
                        PH_TAG:
                        begin
                            field_port_next    = (varint_val[34:3] == 32'd1);
                            field_payload_next = (varint_val[34:3] == 32'd2);
                            if (varint_val[34:3] == 32'd0)
                            begin
                                error_next = 1'b1;
                            end
                            else
                            begin
                                case (varint_val[2:0])
                                    WT_VARINT:  phase_next = PH_VAL;
                                    WT_DELIM:   phase_next = PH_LEN;
                                    WT_I32:
                                    begin
                                        skip_next  = SW'(FIXED32_BYTES);
                                        phase_next = PH_SKIP;
                                    end
                                    WT_I64:
                                    begin
                                        skip_next  = SW'(FIXED64_BYTES);
                                        phase_next = PH_SKIP;
                                    end
                                    default:    error_next = 1'b1;
                                endcase
                            end
                        end
                        PH_VAL:
                        begin
                            if (field_port_reg)
                            begin
                                port_next = varint_val[PORT_W-1:0];
                            end
                            phase_next = PH_TAG;
                        end
                        default:
                        begin
                            if (field_payload_reg)
                            begin
                                start_next = SW'(pos_reg) + SW'(1);
                                size_next  = varint_val[PAYLOAD_W-1:0];
                                seen_next  = 1'b1;
                            end
                            if (varint_val == '0)
                            begin
                                phase_next = PH_TAG;
                            end
                            else
                            begin
                                skip_next  = len_clamped;
                                phase_next = PH_SKIP;
                            end
                        end
                    endcase
                end
            end

            if (!beat.final_byte)
            begin
                if (pos_reg == POS_LAST)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + PB'(1);
                end
            end
            else
            begin
                // The message ends cleanly only between fields. The result is
                // taken from the state this byte produced, before the clear.
                res_valid = 1'b1;
                ok = !error_next && (phase_next == PH_TAG) && (count_next == '0);
                res.parse_ok = ok;
                if (ok)
                begin
                    res.port_number = port_next;
                    if (seen_next)
                    begin
                        res.payload_present = 1'b1;
                        res.payload_offset  = PAYLOAD_W'(start_next);
                        res.payload_length  = size_next;
                    end
                end
                phase_next         = PH_TAG;
                accum_next         = '0;
                count_next         = '0;
                field_port_next    = 1'b0;
                field_payload_next = 1'b0;
                skip_next          = '0;
                pos_next           = '0;
                port_next          = '0;
                start_next         = '0;
                size_next          = '0;
                seen_next          = 1'b0;
                error_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_TAG;
            accum_reg         <= '0;
            count_reg         <= '0;
            field_port_reg    <= 1'b0;
            field_payload_reg <= 1'b0;
            skip_reg          <= '0;
            pos_reg           <= '0;
            port_reg          <= '0;
            start_reg         <= '0;
            size_reg          <= '0;
            seen_reg          <= 1'b0;
            error_reg         <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            accum_reg         <= accum_next;
            count_reg         <= count_next;
            field_port_reg    <= field_port_next;
            field_payload_reg <= field_payload_next;
            skip_reg          <= skip_next;
            pos_reg           <= pos_next;
            port_reg          <= port_next;
            start_reg         <= start_next;
            size_reg          <= size_next;
            seen_reg          <= seen_next;
            error_reg         <= error_next;
        end
    end

endmodule

`default_nettype wire

@@ design/ppp_result_stage.sv @@
`default_nettype none

module ppp_result_stage
    import ppp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         out_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ design/protobuf_port_payload_parser.sv @@
`default_nettype none

// Streaming protobuf wire-format parser that pulls a port number (field 1,
// varint) and the location of a payload (field 2, length-delimited) out of a
// message delivered one byte per beat, with tlast on the message's last byte.
// Tags, varint values and length prefixes are decoded as base-128 varints;
// all other fields are skipped by wire type (8 bytes, 4 bytes or the length
// prefix). Exactly one result beat is produced per message, when its last
// byte has been processed; parse_ok is 0 for field number 0, wire types 3, 4,
// 6 or 7, an eleventh varint byte, a message that ends inside a field, or a
// message longer than 2**POSITION_BITS bytes, and then every other result
// field is 0. The block takes one byte every clock cycle while s_tready is
// high: while a byte sits in the input register, combinational decode works
// out the next running state and, for a last byte, the result; the edge that
// moves the byte on loads both, and m_tvalid rises with the loaded result.
// s_tready drops only while a last byte is held and the output register still
// holds an untaken result. The parser returns to its reset state after each
// last byte, so messages may follow each other with no gap.

module protobuf_port_payload_parser
    import ppp_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata[7:0]: data_byte
    input  wire logic [7:0]           s_tdata,
    // s_tlast: final_byte
    input  wire logic                 s_tlast,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, lowest bit up: parse_ok [0], port_number [32:1],
    // payload_present [33], payload_offset [49:34], payload_length [65:50],
    // zero padding [71:66].
    output logic [M_TDATA_W-1:0]      m_tdata
);

    byte_beat_t beat;
    logic       out_free;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // Input register: holds one byte; it moves on unless it is a last byte
    // waiting for room in the output register.
    ppp_byte_stage u_byte_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_final (s_tlast),
        .out_free (out_free),
        .beat     (beat)
    );

    // Decode state: varint accumulator, phase, skip counter, byte position
    // and the captured port and payload fields.
    ppp_decoder #(
        .POSITION_BITS (POSITION_BITS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register for the one result of each message.
    ppp_result_stage u_result_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // The struct packs parse_ok into the lowest bit, matching the layout
    // listed at the port.
    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, out_res};

endmodule

`default_nettype wire
